@@ rtl/utf8d_pkg.sv @@
// Shared types and constants for the UTF-8 decoder.
// Holds the byte classes, the queued word layout and the result status codes.
// No dependencies.
`default_nettype none

package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 21;
  localparam int unsigned StatW = 2;

  // Result status codes.
  localparam logic [StatW-1:0] STATUS_ASCII = 2'd0;
  localparam logic [StatW-1:0] STATUS_MULTI = 2'd1;
  localparam logic [StatW-1:0] STATUS_ERROR = 2'd2;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_INVALID
  } byte_class_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    byte_class_e      cls;
  } cls_word_t;

endpackage

`default_nettype wire

@@ rtl/utf8d_front.sv @@
// Front end of the UTF-8 decoder: sorts each incoming byte into its class.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_front (
  input  logic [7:0]           byte_in_i,
  output utf8d_pkg::cls_word_t word_o
);
  import utf8d_pkg::*;

  byte_class_e cls;

  always_comb begin
    priority casez (byte_in_i)
      8'b0???????: cls = CLS_ASCII;
      8'b10??????: cls = CLS_CONT;
      8'b110?????: cls = CLS_LEAD2;
      8'b1110????: cls = CLS_LEAD3;
      8'b11110???: cls = CLS_LEAD4;
      default:     cls = CLS_INVALID;
    endcase
  end

  assign word_o.data = byte_in_i;
  assign word_o.cls  = cls;

endmodule

`default_nettype wire

@@ rtl/utf8d_fifo.sv @@
// Small queue that carries classified words from the front end to the back end.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  utf8d_pkg::cls_word_t wdata_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output utf8d_pkg::cls_word_t rdata_o,
  output logic                 empty_o
);
  import utf8d_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  cls_word_t        mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/utf8d_back.sv @@
// Back end of the UTF-8 decoder: sequence state, code point assembly and the
// result register. Depends on utf8d_pkg.
`default_nettype none

module utf8d_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  utf8d_pkg::cls_word_t word_i,
  input  logic                 word_valid_i,
  output logic                 word_take_o,
  output logic                 res_valid_o,
  input  logic                 res_pop_i,
  output logic [20:0]          code_point_o,
  output logic [1:0]           status_o,
  output logic [7:0]           bad_byte_o
);
  import utf8d_pkg::*;

  logic [1:0]       phase_q, phase_d;
  logic [CodeW-1:0] partial_q, partial_d;
  logic             res_valid_q, res_valid_d;
  logic [CodeW-1:0] cp_q, cp_d;
  logic [StatW-1:0] stat_q, stat_d;
  logic [ByteW-1:0] bad_q, bad_d;

  logic             emit;
  logic [CodeW-1:0] cont_bits;
  logic [CodeW-1:0] merged;
  logic [1:0]       phase_dec;

  // A queued word is taken whenever the result slot is free or being emptied.
  assign word_take_o = word_valid_i && (!res_valid_q || res_pop_i);
  assign phase_dec   = phase_q - 2'd1;

  always_comb begin
    unique case (phase_dec)
      2'd0:    cont_bits = CodeW'(word_i.data[5:0]);
      2'd1:    cont_bits = CodeW'(word_i.data[5:0]) << 6;
      2'd2:    cont_bits = CodeW'(word_i.data[5:0]) << 12;
      default: cont_bits = CodeW'(word_i.data[5:0]) << 18;
    endcase
  end

  assign merged = partial_q | cont_bits;

  always_comb begin
    phase_d   = phase_q;
    partial_d = partial_q;
    emit      = 1'b0;
    cp_d      = cp_q;
    stat_d    = stat_q;
    bad_d     = bad_q;
    if (word_take_o) begin
      if (phase_q == 2'd0) begin
        unique case (word_i.cls)
          CLS_ASCII: begin
            emit   = 1'b1;
            cp_d   = CodeW'(word_i.data);
            stat_d = STATUS_ASCII;
            bad_d  = '0;
          end
          CLS_LEAD2: begin
            partial_d = CodeW'(word_i.data[4:0]) << 6;
            phase_d   = 2'd1;
          end
          CLS_LEAD3: begin
            partial_d = CodeW'(word_i.data[3:0]) << 12;
            phase_d   = 2'd2;
          end
          CLS_LEAD4: begin
            partial_d = CodeW'(word_i.data[2:0]) << 18;
            phase_d   = 2'd3;
          end
          default: begin
            emit   = 1'b1;
            cp_d   = '0;
            stat_d = STATUS_ERROR;
            bad_d  = word_i.data;
          end
        endcase
      end else if (word_i.cls != CLS_CONT) begin
        // The pending sequence is dropped and the offending byte reported.
        phase_d   = 2'd0;
        partial_d = '0;
        emit      = 1'b1;
        cp_d      = '0;
        stat_d    = STATUS_ERROR;
        bad_d     = word_i.data;
      end else if (phase_dec == 2'd0) begin
        phase_d   = 2'd0;
        partial_d = '0;
        emit      = 1'b1;
        cp_d      = merged;
        stat_d    = STATUS_MULTI;
        bad_d     = '0;
      end else begin
        phase_d   = phase_dec;
        partial_d = merged;
      end
    end
    res_valid_d = emit || (res_valid_q && !res_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 2'd0;
      partial_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      partial_q   <= partial_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q   <= cp_d;
    stat_q <= stat_d;
    bad_q  <= bad_d;
  end

  assign res_valid_o  = res_valid_q;
  assign code_point_o = cp_q;
  assign status_o     = stat_q;
  assign bad_byte_o   = bad_q;

endmodule

`default_nettype wire

@@ rtl/utf8_decoder_unit.sv @@
// UTF-8 decoder, one byte per word in, one code point or error per result.
// Path: byte -> queue -> back end result register -> ports. Throughput: one
// byte per cycle while the result slot is free or popped, set by the single
// decode register in the back end; the queue of Depth words absorbs stalls.
// Reset: asynchronous, active low; empties queue and result slot, phase idle.
`default_nettype none

module utf8_decoder_unit #(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [20:0] code_point_o,
  output logic [1:0]  status_o,
  output logic [7:0]  bad_byte_o
);
  import utf8d_pkg::*;

  cls_word_t front_word;
  cls_word_t q_word;
  logic      q_full, q_empty, q_pop;
  logic      res_valid;

  utf8d_front u_front (
    .byte_in_i (byte_in_i),
    .word_o    (front_word)
  );

  utf8d_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_word),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_word),
    .empty_o (q_empty)
  );

  utf8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (q_word),
    .word_valid_i (!q_empty),
    .word_take_o  (q_pop),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop),
    .code_point_o (code_point_o),
    .status_o     (status_o),
    .bad_byte_o   (bad_byte_o)
  );

  assign full  = q_full;
  assign empty = !res_valid;

  a_queue_sane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue reports full and empty at once");

  a_take_needs_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end took a word from an empty queue");

  a_status_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == STATUS_ASCII || status_o == STATUS_MULTI ||
                status_o == STATUS_ERROR))
    else $error("result carries an undefined status");

  a_error_zero_cp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STATUS_ERROR) |-> (code_point_o == '0))
    else $error("error result carries a nonzero code point");

  a_take_after_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && !empty) |-> pop)
    else $error("back end overwrote a result that was not taken");

endmodule

`default_nettype wire
